>>> sv/opw_pkg.sv
// shared constants, types and command/status structs of the page-mode pixel writer
`timescale 1ns / 1ps

package opw_pkg;

  // panel geometry
  localparam int PANEL_WIDTH  = 64;
  localparam int PANEL_HEIGHT = 48;

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  // controller command codes
  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;
  localparam logic [7:0] COL_LOW_MASK = 8'h0F;
  localparam logic [3:0] OFFSET_RESET = 4'h2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BEAT_PAGE,
    BEAT_COL_HI,
    BEAT_COL_LO,
    BEAT_DATA
  } beat_t;

  typedef struct packed {
    logic  clr_we;    // write zero at the sweep address
    logic  capture;   // pixel beat accepted
    logic  modify;    // write back the updated page byte
    logic  load_out;  // load the output register
    beat_t beat;      // which byte to load
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;   // sweep at the final entry
    logic in_range;   // offered pixel lies inside the panel
    logic out_free;   // output register can take a beat
  } dp_status_t;

endpackage

>>> sv/opw_if.sv
// valid/ready channel interfaces for pixel requests, link bytes and configuration
`timescale 1ns / 1ps

interface opw_pixel_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;

  modport source (output valid, func, pixel_x, pixel_y, input ready);
  modport sink (input valid, func, pixel_x, pixel_y, output ready);
endinterface

interface opw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, out_byte, is_data, last, input ready);
  modport sink (input valid, out_byte, is_data, last, output ready);
endinterface

interface opw_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] column_high_offset;

  modport source (output valid, column_high_offset, input ready);
  modport sink (input valid, column_high_offset, output ready);
endinterface

>>> sv/opw_ctrl.sv
// controller state machine: clearing sweep, accept, read-modify-write, byte sequencing
`timescale 1ns / 1ps

module opw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  opw_pkg::dp_status_t status,
  output opw_pkg::dp_cmd_t    cmd
);

  opw_pkg::state_t state, state_next;
  opw_pkg::beat_t  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= opw_pkg::ST_CLEAR;
      cnt   <= opw_pkg::BEAT_PAGE;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    cmd.clr_we   = 1'b0;
    cmd.capture  = 1'b0;
    cmd.modify   = 1'b0;
    cmd.load_out = 1'b0;
    cmd.beat     = cnt;
    case (state)
      opw_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (status.clr_last) begin
          state_next = opw_pkg::ST_IDLE;
        end
      end
      opw_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid && status.in_range) begin
          state_next = opw_pkg::ST_MODIFY;
        end
      end
      opw_pkg::ST_MODIFY: begin
        cmd.modify = 1'b1;
        cmd.beat   = opw_pkg::BEAT_PAGE;
        state_next = opw_pkg::ST_EMIT;
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cnt_next     = opw_pkg::BEAT_COL_HI;
        end else begin
          cnt_next = opw_pkg::BEAT_PAGE;
        end
      end
      opw_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (cnt == opw_pkg::BEAT_DATA) begin
            // last beat goes out while the next pixel is taken
            in_ready    = 1'b1;
            cmd.capture = in_valid;
            cnt_next    = opw_pkg::BEAT_PAGE;
            if (in_valid && status.in_range) begin
              state_next = opw_pkg::ST_MODIFY;
            end else begin
              state_next = opw_pkg::ST_IDLE;
            end
          end else begin
            cnt_next = opw_pkg::beat_t'(cnt + 2'd1);
          end
        end
      end
      default: begin
        state_next = opw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/opw_dp.sv
// datapath: frame store, request registers, offset register and output register
`timescale 1ns / 1ps

module opw_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_offset,
  input  logic                func,
  input  logic [7:0]          pixel_x,
  input  logic [7:0]          pixel_y,
  input  opw_pkg::dp_cmd_t    cmd,
  output opw_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                is_data,
  output logic                last
);

  logic [7:0] mem [opw_pkg::STORE_DEPTH];
  logic [7:0] rdata;

  logic [opw_pkg::ADDR_W-1:0] clr_addr;
  logic [opw_pkg::ADDR_W-1:0] req_addr;
  logic [opw_pkg::ADDR_W-1:0] in_addr;
  logic [opw_pkg::ADDR_W-1:0] waddr;
  logic [15:0]                addr_full;
  logic [opw_pkg::PAGE_W-1:0] in_page;
  logic [opw_pkg::PAGE_W-1:0] req_page;
  logic [7:0]                 req_x;
  logic [2:0]                 req_bit;
  logic                       req_func;
  logic [3:0]                 offset;
  logic [7:0]                 data_byte;
  logic [7:0]                 new_byte;
  logic [7:0]                 bit_mask;
  logic [7:0]                 wdata;
  logic [7:0]                 beat_byte;
  logic                       we;

  assign in_page   = pixel_y[opw_pkg::PAGE_W+2:3];
  assign addr_full = 16'(pixel_x) * 16'(opw_pkg::PAGE_COUNT) + 16'(in_page);
  assign in_addr   = addr_full[opw_pkg::ADDR_W-1:0];

  assign status.in_range = ({1'b0, pixel_x} < 9'(opw_pkg::PANEL_WIDTH)) &&
                           ({1'b0, pixel_y} < 9'(opw_pkg::PANEL_HEIGHT));
  assign status.clr_last = (clr_addr == opw_pkg::ADDR_W'(opw_pkg::STORE_DEPTH - 1));
  assign status.out_free = !out_valid || out_ready;

  // set or clear one bit of the page byte
  assign bit_mask = 8'b1 << req_bit;
  assign new_byte = req_func ? (rdata & ~bit_mask) : (rdata | bit_mask);

  assign we    = cmd.clr_we || cmd.modify;
  assign waddr = cmd.clr_we ? clr_addr : req_addr;
  assign wdata = cmd.clr_we ? 8'h00 : new_byte;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      offset   <= opw_pkg::OFFSET_RESET;
    end else begin
      if (cmd.clr_we) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_we) begin
        offset <= cfg_offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_addr <= in_addr;
      req_page <= in_page;
      req_x    <= pixel_x;
      req_bit  <= pixel_y[2:0];
      req_func <= func;
    end
    if (cmd.modify) begin
      data_byte <= new_byte;
    end
  end

  always_comb begin
    case (cmd.beat)
      opw_pkg::BEAT_PAGE:   beat_byte = opw_pkg::CMD_PAGE | 8'(req_page);
      opw_pkg::BEAT_COL_HI: beat_byte = (opw_pkg::CMD_COL_HIGH | {4'b0, req_x[7:4]}) +
                                        {4'b0, offset};
      opw_pkg::BEAT_COL_LO: beat_byte = req_x & opw_pkg::COL_LOW_MASK;
      opw_pkg::BEAT_DATA:   beat_byte = data_byte;
      default:              beat_byte = data_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte <= beat_byte;
      is_data  <= (cmd.beat == opw_pkg::BEAT_DATA);
      last     <= (cmd.beat == opw_pkg::BEAT_DATA);
    end
  end

endmodule

>>> sv/oled_page_pixel_writer.sv
// top level of the page-mode pixel writer: controller, datapath and channel hookup
`timescale 1ns / 1ps

// Takes pixel set/clear requests and turns each one inside the panel into a
// four-beat run for the display link: page-address command, column-high
// command (with the programmable column offset added), column-low command,
// then the updated page byte flagged with is_data and last. A shadow copy of
// the panel (one byte per column per 8-row page) lives in an internal block
// memory and is updated by read-modify-write. Requests outside the panel are
// accepted and dropped with no output. The four beats of an in-panel pixel
// leave through a single output register, and the next pixel is accepted on
// the cycle the data beat is loaded. After reset the store is swept to zero,
// one entry per cycle, over all STORE_DEPTH (384 for a 64x48 panel) entries;
// the pixel input is not ready during the sweep, configuration writes are
// taken at any time but are meant only while the block is idle.

module oled_page_pixel_writer (
  input  logic              clk,
  input  logic              rst,
  opw_pixel_if.sink         pixel,
  opw_cfg_if.sink           cfg,
  opw_byte_if.source        link
);

  opw_pkg::dp_cmd_t    cmd;
  opw_pkg::dp_status_t status;

  // offset register is always writable
  assign cfg.ready = 1'b1;

  // sequencer: sweep, accept, modify, then four link beats
  opw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel.valid),
    .in_ready (pixel.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // store, request capture and output register
  opw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_offset (cfg.column_high_offset),
    .func       (pixel.func),
    .pixel_x    (pixel.pixel_x),
    .pixel_y    (pixel.pixel_y),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (link.valid),
    .out_ready  (link.ready),
    .out_byte   (link.out_byte),
    .is_data    (link.is_data),
    .last       (link.last)
  );

endmodule

>>> tb/tb_oled_page_pixel_writer.sv
// testbench for the page-mode pixel writer: predicted link beats checked against the block
`timescale 1ns / 1ps

module tb_oled_page_pixel_writer;

  // sweep after reset plus every beat under worst stalls, taken many times over
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD    = 60;
  localparam int REPORT_MAX   = 10;

  // one beat expected on the link
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } link_beat_t;

  // one directed row: beats are page, col-high, col-low, data from msb down
  typedef struct packed {
    logic        clr;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        typed;   // beats below are written out by hand
    logic        quiet;   // hand-typed row that leaves the link silent
    logic [31:0] beats;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // fresh store, reset offset of 2
    '{1'b0, 8'd0,   8'd0,   1'b1, 1'b0, 32'hB0_12_00_01},
    '{1'b0, 8'd63,  8'd47,  1'b1, 1'b0, 32'hB5_15_0F_80},
    '{1'b1, 8'd63,  8'd47,  1'b1, 1'b0, 32'hB5_15_0F_00},
    // just past the right and bottom edges, and the far corner
    '{1'b0, 8'd64,  8'd0,   1'b1, 1'b1, 32'h0},
    '{1'b0, 8'd0,   8'd48,  1'b1, 1'b1, 32'h0},
    '{1'b1, 8'd255, 8'd255, 1'b1, 1'b1, 32'h0},
    '{1'b1, 8'd0,   8'd0,   1'b1, 1'b0, 32'hB0_12_00_00},
    '{1'b0, 8'd0,   8'd7,   1'b1, 1'b0, 32'hB0_12_00_80},
    // same page byte hit back to back
    '{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 32'h0},
    '{1'b0, 8'd0,   8'd3,   1'b0, 1'b0, 32'h0},
    '{1'b1, 8'd0,   8'd7,   1'b0, 1'b0, 32'h0},
    // each column-high nibble
    '{1'b0, 8'd16,  8'd8,   1'b0, 1'b0, 32'h0},
    '{1'b0, 8'd32,  8'd15,  1'b0, 1'b0, 32'h0},
    '{1'b0, 8'd48,  8'd40,  1'b0, 1'b0, 32'h0},
    // clearing a pixel that is already clear
    '{1'b1, 8'd5,   8'd30,  1'b0, 1'b0, 32'h0},
    '{1'b0, 8'd63,  8'd0,   1'b1, 1'b0, 32'hB0_15_0F_01},
    '{1'b0, 8'd0,   8'd47,  1'b1, 1'b0, 32'hB5_12_00_80},
    '{1'b0, 8'd63,  8'd48,  1'b1, 1'b1, 32'h0},
    '{1'b1, 8'd64,  8'd47,  1'b1, 1'b1, 32'h0},
    '{1'b0, 8'd128, 8'd0,   1'b1, 1'b1, 32'h0},
    '{1'b0, 8'd0,   8'd128, 1'b1, 1'b1, 32'h0},
    '{1'b1, 8'd85,  8'd170, 1'b1, 1'b1, 32'h0},
    '{1'b0, 8'd127, 8'd63,  1'b1, 1'b1, 32'h0},
    '{1'b0, 8'd47,  8'd23,  1'b0, 1'b0, 32'h0},
    '{1'b1, 8'd47,  8'd23,  1'b0, 1'b0, 32'h0}
  };

  logic clk;
  logic rst;

  opw_pixel_if pixel_ch ();
  opw_cfg_if   cfg_ch ();
  opw_byte_if  link_ch ();

  oled_page_pixel_writer i_dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_ch),
    .cfg   (cfg_ch),
    .link  (link_ch)
  );

  // shadow of the panel and of the offset register
  logic [7:0]  frame_shadow [opw_pkg::STORE_DEPTH];
  logic [3:0]  col_offset;
  link_beat_t  link_beats_due [$];

  int mismatch_count;
  int cycle_count;

  // idling controls for the sender (gaps) and the receiver (stalls, holds)
  bit gaps_on;
  bit stalls_on;
  int hold_asks;
  int holds_done;

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // read-modify-write of one page byte, gives the four link bytes
  function automatic bit paint_pixel(input logic clr, input logic [7:0] x,
                                     input logic [7:0] y, output logic [31:0] beats);
    int unsigned page;
    int unsigned idx;
    logic [7:0]  page_byte;
    logic [7:0]  col_hi;
    beats = '0;
    if (x >= opw_pkg::PANEL_WIDTH || y >= opw_pkg::PANEL_HEIGHT) return 1'b0;
    page = y >> 3;
    idx = x * opw_pkg::PAGE_COUNT + page;
    page_byte = frame_shadow[idx];
    page_byte[y[2:0]] = !clr;
    frame_shadow[idx] = page_byte;
    // column-high sum keeps only its low byte
    col_hi = (opw_pkg::CMD_COL_HIGH | {4'h0, x[7:4]}) + {4'h0, col_offset};
    beats = {opw_pkg::CMD_PAGE | 8'(page), col_hi, x & opw_pkg::COL_LOW_MASK, page_byte};
    return 1'b1;
  endfunction

  // split a four-byte run into beats waiting for the link
  task automatic queue_run(input logic [31:0] beats);
    link_beat_t b;
    for (int k = 0; k < 4; k++) begin
      b.out_byte = beats[31 - 8 * k -: 8];
      b.is_data  = (k == int'(opw_pkg::BEAT_DATA));
      b.last     = (k == int'(opw_pkg::BEAT_DATA));
      link_beats_due.push_back(b);
    end
  endtask

  // offer one pixel beat, wait for it to be taken, then predict
  task automatic drive_pixel(input logic clr, input logic [7:0] x, input logic [7:0] y,
                             input logic typed, input logic quiet,
                             input logic [31:0] typed_beats);
    bit          lands;
    logic [31:0] model_beats;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      pixel_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pixel_ch.valid   = 1'b1;
    pixel_ch.func    = clr;
    pixel_ch.pixel_x = x;
    pixel_ch.pixel_y = y;
    do @(posedge clk); while (!pixel_ch.ready);
    // the shadow store moves on every accepted pixel, typed or not
    lands = paint_pixel(clr, x, y, model_beats);
    if (typed) begin
      if (!quiet) queue_run(typed_beats);
    end else if (lands) begin
      queue_run(model_beats);
    end
  endtask

  // drop valid and let every expected beat come out, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    pixel_ch.valid = 1'b0;
    while (link_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one beat on the configuration channel
  task automatic write_offset(input logic [3:0] v);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.column_high_offset = v;
    do @(posedge clk); while (!cfg_ch.ready);
    col_offset = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // random pixels until the wanted number landed inside the panel
  task automatic run_random(input int want);
    int         landed;
    int         pick;
    int         hot_x;
    int         hot_y;
    logic       clr;
    logic [7:0] x;
    logic [7:0] y;
    landed = 0;
    hot_x = 0;
    hot_y = 0;
    while (landed < want) begin
      // move the hot spot now and then so page bytes get hit repeatedly
      if (landed % 16 == 0) begin
        hot_x = $urandom_range(0, opw_pkg::PANEL_WIDTH - 4);
        hot_y = 8 * $urandom_range(0, opw_pkg::PAGE_COUNT - 1);
      end
      pick = $urandom_range(0, 99);
      clr = ($urandom_range(0, 2) == 0);
      if (pick < 12) begin
        // noise off the panel edge, sweeps the upper coordinate bits
        if (pick % 2 == 0) begin
          x = 8'($urandom_range(opw_pkg::PANEL_WIDTH, 255));
          y = 8'($urandom);
        end else begin
          x = 8'($urandom);
          y = 8'($urandom_range(opw_pkg::PANEL_HEIGHT, 255));
        end
      end else if (pick < 50) begin
        x = 8'(hot_x + $urandom_range(0, 3));
        y = 8'(hot_y + $urandom_range(0, 7));
      end else begin
        x = 8'($urandom_range(0, opw_pkg::PANEL_WIDTH - 1));
        y = 8'($urandom_range(0, opw_pkg::PANEL_HEIGHT - 1));
      end
      drive_pixel(clr, x, y, 1'b0, 1'b0, '0);
      if (x < opw_pkg::PANEL_WIDTH && y < opw_pkg::PANEL_HEIGHT) landed++;
    end
  endtask

  // link receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int hold_left;
    link_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks > holds_done) begin
        link_ch.ready = 1'b0;
        hold_left = LONG_HOLD;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
        holds_done++;
        link_ch.ready = 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        link_ch.ready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        link_ch.ready = 1'b1;
      end else begin
        link_ch.ready = 1'b1;
      end
    end
  end

  // every link beat against the oldest expectation
  always @(posedge clk) begin
    link_beat_t want;
    if (!rst && link_ch.valid && link_ch.ready) begin
      if (link_beats_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected beat: byte %h is_data %b last %b",
                   link_ch.out_byte, link_ch.is_data, link_ch.last);
      end else begin
        want = link_beats_due.pop_front();
        if (link_ch.out_byte !== want.out_byte || link_ch.is_data !== want.is_data ||
            link_ch.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("beat mismatch: want byte %h is_data %b last %b, got %h %b %b",
                     want.out_byte, want.is_data, want.last,
                     link_ch.out_byte, link_ch.is_data, link_ch.last);
        end
      end
    end
  end

  // hard stop if the run hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_oled_page_pixel_writer: done, errors");
    $finish;
  end

  // stimulus and phases
  initial begin
    rst = 1'b1;
    pixel_ch.valid   = 1'b0;
    pixel_ch.func    = 1'b0;
    pixel_ch.pixel_x = '0;
    pixel_ch.pixel_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.column_high_offset = opw_pkg::OFFSET_RESET;
    foreach (frame_shadow[i]) frame_shadow[i] = '0;
    col_offset = opw_pkg::OFFSET_RESET;
    mismatch_count = 0;
    hold_asks = 0;
    holds_done = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed rows at the reset offset; first one waits out the clearing sweep
    foreach (DIRECTED[i])
      drive_pixel(DIRECTED[i].clr, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].typed,
                  DIRECTED[i].quiet, DIRECTED[i].beats);

    // top offset, both sides idling in bursts
    wait_drained();
    write_offset(4'hF);
    run_random(65);

    // zero offset, no idling, receiver holds off long enough to back up the input
    wait_drained();
    write_offset(4'h0);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_asks++;
    run_random(65);

    // mid-range offset, bursts again, with a full drain in the middle
    wait_drained();
    write_offset(4'($urandom_range(1, 14)));
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    run_random(32);
    wait_drained();
    run_random(32);

    // closing stretch at full rate
    wait_drained();
    write_offset(4'($urandom));
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_random(56);

    wait_drained();
    if (mismatch_count == 0 && link_beats_due.size() == 0) begin
      $display("tb_oled_page_pixel_writer: done, clean");
    end else begin
      $display("tb_oled_page_pixel_writer: done, errors");
    end
    $finish;
  end

endmodule
